### rtl/asp_pkg.sv
// Shared types and constants for the audio sample packetizer.
// No dependencies; imported by every module of the block.
package asp_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_FORMAT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 2'd2;

	localparam int CFG_DATA_W = 32;

	// Sample encodings
	localparam logic [1:0] FMT_FLOAT32 = 2'd0;
	localparam logic [1:0] FMT_PCM16   = 2'd1;
	localparam logic [1:0] FMT_PCM24   = 2'd2;
	localparam logic [1:0] FMT_PCM32   = 2'd3;

	// Register reset values
	localparam logic [1:0]  RST_FORMAT   = FMT_PCM16;
	localparam logic [1:0]  RST_CHANNELS = 2'd2;
	localparam logic [31:0] RST_RATE     = 32'd48000;

	localparam int MAX_PACKET_FRAMES_DEF = 240;

	// Lane result kinds
	localparam logic [1:0] KIND_ZERO = 2'd0;
	localparam logic [1:0] KIND_PASS = 2'd1;
	localparam logic [1:0] KIND_SAT  = 2'd2;
	localparam logic [1:0] KIND_CALC = 2'd3;

	localparam logic [14:0] SAMPLE_SCALE = 15'd32767;
	localparam logic [15:0] SAMPLE_MAX   = 16'd32767;

	// Packet layout (byte offsets within one frame's byte image)
	localparam logic [31:0] HDR_MAGIC     = 32'h32414D42; // "BMA2", low byte first
	localparam logic [7:0]  HDR_BITS      = 8'd16;
	localparam int          FRAME_BYTES   = 20;
	localparam int          BIDX_W        = 5;
	localparam logic [BIDX_W-1:0] BIDX_HDR_START = 5'd0;
	localparam logic [BIDX_W-1:0] BIDX_PAYLOAD   = 5'd16;
	localparam logic [BIDX_W-1:0] BIDX_LAST_MONO = 5'd17;
	localparam logic [BIDX_W-1:0] BIDX_LAST_STEREO = 5'd19;

	typedef struct packed {
		logic [31:0] left_raw;
		logic [31:0] right_raw;
		logic        is_silent;
		logic [15:0] frames_left;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       packet_end;
		logic       item_end;
	} out_item_t;

	// Converted frame handed from the lanes to the packer
	typedef struct packed {
		logic [15:0] smp_l;
		logic [15:0] smp_r;
		logic [15:0] frame_cnt;
	} frame_t;

endpackage

### rtl/audio_sample_packetizer_unit.sv
// Audio sample packetizer: top level with config registers, two lanes and the packer.
// Depends on asp_pkg, asp_lane, asp_packer.
//
// Takes one audio frame per input beat and emits a little-endian byte stream, one byte
// per output beat. Each packet opens with a 16-byte header ("BMA2", a wrapping 32-bit
// sequence number, rate_hz, the channel count, the value 16 and the frame count
// min(MAX_PACKET_FRAMES, frames_left)), followed by that many frames of signed 16-bit
// samples, low byte first, left before right. item_end marks the last byte of each
// frame and packet_end the last byte of each packet. A channel_count of 0 acts as 1
// and 3 as 2; frames_left of 0 acts as 1. Throughput is set by the byte-wide output
// register: a stereo frame is 4 bytes, a mono frame 2, and a frame that opens a
// packet 16 more. Input beats are taken back to back while the two conversion stages
// and the packer's frame buffer have room, so a new frame enters while the previous
// one is still being sent; the frame buffer feeds the output register.
// Configuration writes belong only to idle periods; the registers are read live.
module audio_sample_packetizer_unit import asp_pkg::*; #(
	parameter int MAX_PACKET_FRAMES = MAX_PACKET_FRAMES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data
);

	logic [1:0]  format_q;
	logic [1:0]  channels_q;
	logic [31:0] rate_q;

	logic        v_s1;
	logic        v_s2;
	logic [15:0] cnt_s1;
	logic [15:0] cnt_s2;
	logic        ready_s1;
	logic        ready_s2;
	logic [15:0] avail;
	logic [15:0] cnt_d;
	frame_t      frame;
	logic        frame_take;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q   <= RST_FORMAT;
			channels_q <= RST_CHANNELS;
			rate_q     <= RST_RATE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FORMAT:   format_q   <= cfg_data[1:0];
				CFG_CHANNELS: channels_q <= cfg_data[1:0];
				CFG_RATE:     rate_q     <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Pipeline flow: a stage advances when the next one is empty or moving.
	assign ready_s2 = !v_s2 || frame_take;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1)
				v_s1 <= in_valid;
			if (ready_s2)
				v_s2 <= v_s1;
		end
	end

	// Frame count of a packet that this frame would open
	assign avail = (in_data.frames_left == 16'd0) ? 16'd1 : in_data.frames_left;
	assign cnt_d = (avail < 16'(MAX_PACKET_FRAMES)) ? avail : 16'(MAX_PACKET_FRAMES);

	always_ff @(posedge clk) begin
		if (ready_s1)
			cnt_s1 <= cnt_d;
		if (ready_s2)
			cnt_s2 <= cnt_s1;
	end

	asp_lane u_lane_l (
		.clk    (clk),
		.en_s1  (ready_s1),
		.en_s2  (ready_s2),
		.raw    (in_data.left_raw),
		.fmt    (format_q),
		.silent (in_data.is_silent),
		.smp    (frame.smp_l)
	);

	asp_lane u_lane_r (
		.clk    (clk),
		.en_s1  (ready_s1),
		.en_s2  (ready_s2),
		.raw    (in_data.right_raw),
		.fmt    (format_q),
		.silent (in_data.is_silent),
		.smp    (frame.smp_r)
	);

	assign frame.frame_cnt = cnt_s2;

	// Merge both lanes into the byte stream; two channels whenever bit 1 is set.
	asp_packer #(
		.MAX_PACKET_FRAMES (MAX_PACKET_FRAMES)
	) u_packer (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (v_s2),
		.frame       (frame),
		.frame_take  (frame_take),
		.two_ch      (channels_q[1]),
		.rate_hz     (rate_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

### rtl/asp_lane.sv
// One conversion lane: raw sample word to signed 16 bits, two stages.
// Depends on asp_pkg.
module asp_lane import asp_pkg::*; (
	input  logic        clk,
	input  logic        en_s1,
	input  logic        en_s2,
	input  logic [31:0] raw,
	input  logic [1:0]  fmt,
	input  logic        silent,
	output logic [15:0] smp
);

	logic        sign;
	logic [7:0]  expo;
	logic [22:0] frac;
	logic [1:0]  kind_d;
	logic [15:0] val_d;
	logic [38:0] prod_d;

	logic [1:0]  kind_s1;
	logic        sign_s1;
	logic [15:0] val_s1;
	logic [38:0] prod_s1;
	logic [7:0]  expo_s1;

	logic        lead;
	logic [23:0] r0;
	logic        rbit;
	logic        sticky;
	logic [24:0] rnd;
	logic [7:0]  sh;
	logic [24:0] mag25;
	logic [15:0] mag16;
	logic [15:0] smp_d;
	logic [15:0] smp_s2;

	assign sign = raw[31];
	assign expo = raw[30:23];
	assign frac = raw[22:0];
	assign prod_d = {1'b1, frac} * SAMPLE_SCALE;

	always_comb begin
		kind_d = KIND_ZERO;
		val_d  = raw[15:0];
		if (!silent) begin
			case (fmt)
				FMT_FLOAT32: begin
					if (expo == 8'hFF && frac != 23'd0)
						kind_d = KIND_ZERO;
					else if (expo >= 8'd127)
						kind_d = KIND_SAT;
					else if (expo == 8'd0)
						kind_d = KIND_ZERO; // subnormals scale far below one LSB
					else
						kind_d = KIND_CALC;
				end
				FMT_PCM16: kind_d = KIND_PASS;
				FMT_PCM24: begin
					kind_d = KIND_PASS;
					val_d  = raw[23:8];
				end
				default: begin
					kind_d = KIND_PASS;
					val_d  = raw[31:16];
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			kind_s1 <= kind_d;
			sign_s1 <= sign;
			val_s1  <= val_d;
			prod_s1 <= prod_d;
			expo_s1 <= expo;
		end
	end

	// Round the product to 24 significant bits (nearest even), then shift down.
	always_comb begin
		lead   = prod_s1[38];
		r0     = lead ? prod_s1[38:15] : prod_s1[37:14];
		rbit   = lead ? prod_s1[14] : prod_s1[13];
		sticky = lead ? (|prod_s1[13:0]) : (|prod_s1[12:0]);
		rnd    = {1'b0, r0} + 25'(rbit && (sticky || r0[0]));
		sh     = 8'd136 - expo_s1 - {7'd0, lead};
		mag25  = (sh >= 8'd25) ? 25'd0 : (rnd >> sh[4:0]);
		mag16  = (mag25 > 25'(SAMPLE_MAX)) ? SAMPLE_MAX : mag25[15:0];
		case (kind_s1)
			KIND_ZERO: smp_d = 16'd0;
			KIND_PASS: smp_d = val_s1;
			KIND_SAT:  smp_d = sign_s1 ? (16'd0 - SAMPLE_MAX) : SAMPLE_MAX;
			default:   smp_d = sign_s1 ? (16'd0 - mag16) : mag16;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s2)
			smp_s2 <= smp_d;
	end

	assign smp = smp_s2;

endmodule

### rtl/asp_packer.sv
// Merge stage: frames packet state, builds header and sample bytes, drives output beats.
// Depends on asp_pkg.
module asp_packer import asp_pkg::*; #(
	parameter int MAX_PACKET_FRAMES = MAX_PACKET_FRAMES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        frame_valid,
	input  frame_t      frame,
	output logic        frame_take,
	input  logic        two_ch,
	input  logic [31:0] rate_hz,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data
);

	localparam int FPL_W = $clog2(MAX_PACKET_FRAMES + 1);

	logic                  busy_q;
	logic [BIDX_W-1:0]     idx_q;
	logic [BIDX_W-1:0]     last_q;
	logic                  pend_q;
	logic [8*FRAME_BYTES-1:0] bytes_q;
	logic [31:0]           seq_q;
	logic [FPL_W-1:0]      fpl_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic                  out_free;
	logic                  emit;
	logic                  done;
	logic                  hdr;
	logic [FPL_W-1:0]      fpl_next;
	logic [7:0]            chans;

	assign out_free   = !out_valid_q || !out_stall;
	assign emit       = busy_q && out_free;
	assign done       = emit && (idx_q == last_q);
	assign frame_take = frame_valid && (!busy_q || done);
	assign hdr        = (fpl_q == '0);
	assign fpl_next   = (hdr ? frame.frame_cnt[FPL_W-1:0] : fpl_q) - FPL_W'(1);
	assign chans      = two_ch ? 8'd2 : 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= BIDX_HDR_START;
			seq_q  <= 32'd0;
			fpl_q  <= '0;
		end else if (frame_take) begin
			busy_q <= 1'b1;
			idx_q  <= hdr ? BIDX_HDR_START : BIDX_PAYLOAD;
			fpl_q  <= fpl_next;
			if (hdr)
				seq_q <= seq_q + 32'd1;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (emit) begin
			idx_q <= idx_q + BIDX_W'(1);
		end
	end

	// Byte image of the frame; header bytes are skipped when a packet is open.
	always_ff @(posedge clk) begin
		if (frame_take) begin
			bytes_q <= {frame.smp_r, frame.smp_l, frame.frame_cnt, HDR_BITS, chans,
				rate_hz, seq_q, HDR_MAGIC};
			last_q  <= two_ch ? BIDX_LAST_STEREO : BIDX_LAST_MONO;
			pend_q  <= (fpl_next == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= emit;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_byte   <= bytes_q[{idx_q, 3'b000} +: 8];
			out_q.packet_end <= done && pend_q;
			out_q.item_end   <= done;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### rtl/asp_chk.sv
// Port-level checker for the packetizer top level, with its bind statement.
// Depends on asp_pkg and audio_sample_packetizer_unit.
module asp_chk import asp_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input out_item_t             out_data
);

	logic out_beat;
	logic pkt_start_q;
	logic in_seen_q;

	assign out_beat = out_valid && !out_stall;

	// Next beat opens a packet: true after reset and after each packet_end beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_start_q <= 1'b1;
			in_seen_q   <= 1'b0;
		end else begin
			if (out_beat)
				pkt_start_q <= out_data.packet_end;
			if (in_valid && !in_stall)
				in_seen_q <= 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	a_pend_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.packet_end |-> out_data.item_end)
		else $error("packet end without frame end");

	a_magic: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && pkt_start_q |-> out_data.out_byte == HDR_MAGIC[7:0])
		else $error("packet does not open with header magic");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_seen_q)
		else $error("output beat before any input beat");

endmodule

bind audio_sample_packetizer_unit asp_chk u_asp_chk (.*);

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for audio_sample_packetizer_unit: frames in, packet bytes out.
// Depends on asp_pkg and the RTL only; predicts each byte in-line and scores it on arrival.
module testbench;
	import asp_pkg::*;

	localparam int CLK_PERIOD        = 10;
	localparam int RESET_CYCLES      = 10;
	localparam int FRAMES_PER_PACKET = 240;
	localparam int QUIET_LIMIT       = 2000;  // cycles with no beat before giving up
	localparam int DRAIN_CYCLES      = 12;    // well past the input-to-byte latency
	localparam int IDLE_PERCENT      = 25;

	localparam logic [31:0] PACKET_TAG  = "BMA2";  // first character in the top byte
	localparam logic [7:0]  SAMPLE_BITS = 8'd16;
	localparam logic [31:0] FULL_SCALE  = 32'd32767;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	in_item_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;

	audio_sample_packetizer_unit #(
		.MAX_PACKET_FRAMES(FRAMES_PER_PACKET)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Frames waiting to be driven, and bytes the packetizer still owes us
	in_item_t  frames_to_send [$];
	out_item_t expected_bytes [$];

	// Shadow of the block: register copies plus packet state
	logic [1:0]  pred_format   = FMT_PCM16;
	logic [1:0]  pred_channels = 2'd2;
	logic [31:0] pred_rate     = 32'd48000;
	logic [31:0] pred_seq      = '0;
	int          pred_frames_open = 0;  // frames still owed to the open packet; 0 = none open

	bit        no_idle = 1'b0;
	int        mismatches = 0;
	int        frames_accepted = 0;
	int        bytes_checked = 0;
	int        packets_seen = 0;
	int        settings_used = 0;
	int        quiet_cycles = 0;
	out_item_t want;

	// Float32 to signed 16: NaN gives 0, clamp to [-1,1], scale by 32767, round the
	// product to 24 significant bits (nearest-even), then truncate toward zero.
	function automatic logic [15:0] float_to_sample(input logic [31:0] w);
		logic [7:0]  ex;
		logic [22:0] fr;
		logic [63:0] mant, prod, r, rem, half;
		logic [31:0] mag;
		int          e, len, s, k;
		ex = w[30:23];
		fr = w[22:0];
		if (ex == 8'hFF && fr != '0)
			return 16'h0000;
		if (ex >= 8'd127) begin
			mag = FULL_SCALE;
		end else begin
			if (ex == 8'd0) begin
				mant = {41'd0, fr};
				e = -149;
			end else begin
				mant = {40'd0, 1'b1, fr};
				e = int'(ex) - 150;
			end
			if (mant == '0)
				return 16'h0000;
			prod = mant * 64'(FULL_SCALE);
			len = 0;
			while (len < 64 && (prod >> len) != '0)
				len++;
			s = (len > 24) ? len - 24 : 0;
			r = prod;
			if (s > 0) begin
				rem  = prod & ((64'd1 << s) - 64'd1);
				half = 64'd1 << (s - 1);
				r    = prod >> s;
				if (rem > half || (rem == half && r[0]))
					r++;
			end
			k = e + s;
			if (k >= 0)
				mag = FULL_SCALE;
			else if (-k >= 40)
				mag = '0;
			else
				mag = 32'(r >> (-k));
			if (mag > FULL_SCALE)
				mag = FULL_SCALE;
		end
		return w[31] ? (~mag[15:0] + 16'd1) : mag[15:0];
	endfunction

	function automatic logic [15:0] convert_sample(input logic [31:0] raw);
		case (pred_format)
			FMT_FLOAT32: return float_to_sample(raw);
			FMT_PCM16:   return raw[15:0];
			FMT_PCM24:   return raw[23:8];
			default:     return raw[31:16];
		endcase
	endfunction

	// Work out every byte one accepted frame causes and append them to expected_bytes.
	task automatic packetize_frame(input in_item_t f);
		logic [7:0]  img [$];
		logic [1:0]  chans;
		logic [15:0] avail, cnt;
		logic [15:0] smp [2];
		out_item_t   b;
		bit          closes;
		int          i;
		chans = pred_channels;
		if (chans == 2'd0)
			chans = 2'd1;
		else if (chans == 2'd3)
			chans = 2'd2;
		avail = (f.frames_left == 16'd0) ? 16'd1 : f.frames_left;
		// Open a packet: tag, sequence, rate, channels, bit depth, frame count
		if (pred_frames_open == 0) begin
			cnt = (avail < FRAMES_PER_PACKET) ? avail : 16'(FRAMES_PER_PACKET);
			for (i = 3; i >= 0; i--)
				img.push_back(PACKET_TAG[8*i +: 8]);
			for (i = 0; i < 4; i++)
				img.push_back(pred_seq[8*i +: 8]);
			pred_seq++;
			for (i = 0; i < 4; i++)
				img.push_back(pred_rate[8*i +: 8]);
			img.push_back({6'd0, chans});
			img.push_back(SAMPLE_BITS);
			img.push_back(cnt[7:0]);
			img.push_back(cnt[15:8]);
			pred_frames_open = int'(cnt);
		end
		smp[0] = f.is_silent ? 16'd0 : convert_sample(f.left_raw);
		smp[1] = f.is_silent ? 16'd0 : convert_sample(f.right_raw);
		for (i = 0; i < chans; i++) begin
			img.push_back(smp[i][7:0]);
			img.push_back(smp[i][15:8]);
		end
		pred_frames_open--;
		closes = (pred_frames_open == 0);
		foreach (img[j]) begin
			b.out_byte   = img[j];
			b.item_end   = (j == img.size() - 1);
			b.packet_end = b.item_end && closes;
			expected_bytes.push_back(b);
		end
	endtask

	// Input driver: hold the beat while stalled, otherwise advance or idle at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				packetize_frame(in_data);
				frames_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (frames_to_send.size() != 0 &&
				    (no_idle || $urandom_range(99) >= IDLE_PERCENT)) begin
					in_data  <= frames_to_send.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: score each accepted byte against the oldest expectation,
	// then pick the stall for the next cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				bytes_checked++;
				if (out_data.packet_end === 1'b1)
					packets_seen++;
				if (expected_bytes.size() == 0) begin
					$error("unexpected beat: out_byte 0x%02h, packet_end %b, item_end %b",
					       out_data.out_byte, out_data.packet_end, out_data.item_end);
					mismatches++;
				end else begin
					want = expected_bytes.pop_front();
					if (out_data.out_byte !== want.out_byte) begin
						$error("out_byte: expected 0x%02h, got 0x%02h",
						       want.out_byte, out_data.out_byte);
						mismatches++;
					end
					if (out_data.packet_end !== want.packet_end) begin
						$error("packet_end: expected %b, got %b",
						       want.packet_end, out_data.packet_end);
						mismatches++;
					end
					if (out_data.item_end !== want.item_end) begin
						$error("item_end: expected %b, got %b",
						       want.item_end, out_data.item_end);
						mismatches++;
					end
				end
			end
			out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < IDLE_PERCENT);
		end
	end

	// Watchdog: drop the run if no beat of any kind moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$error("no beat for %0d cycles, %0d bytes still owed",
			       quiet_cycles, expected_bytes.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_FORMAT:   pred_format   = val[1:0];
			CFG_CHANNELS: pred_channels = val[1:0];
			CFG_RATE:     pred_rate     = val;
			default: ;
		endcase
	endtask

	// Write all three registers back to back; only called with the block drained.
	task automatic configure(input logic [1:0] fmt, input logic [1:0] chans,
	                         input logic [31:0] rate);
		write_reg(CFG_FORMAT, {30'd0, fmt});
		write_reg(CFG_CHANNELS, {30'd0, chans});
		write_reg(CFG_RATE, rate);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Block until every frame went in and every byte came out.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (frames_to_send.size() != 0 || in_valid || expected_bytes.size() != 0);
	endtask

	task automatic queue_frame(input logic [31:0] l, input logic [31:0] r,
	                           input logic quiet, input logic [15:0] left);
		in_item_t f;
		f.left_raw    = l;
		f.right_raw   = r;
		f.is_silent   = quiet;
		f.frames_left = left;
		frames_to_send.push_back(f);
	endtask

	// Sample word for the current format; for float32, bias toward the scaled
	// range, with NaN, infinity and subnormal words mixed in.
	function automatic logic [31:0] random_sample();
		int pick;
		pick = $urandom_range(99);
		if (pred_format != FMT_FLOAT32 || pick < 30)
			return $urandom();
		if (pick < 38)
			return {1'($urandom_range(1)), 8'hFF,
			        (pick < 34) ? 23'd0 : 23'($urandom_range(1, 8388607))};
		if (pick < 48)
			return {1'($urandom_range(1)), 8'h00, 23'($urandom())};
		return {1'($urandom_range(1)), 8'($urandom_range(100, 127)), 23'($urandom())};
	endfunction

	// One capture buffer: frames_left counts down from head. Some later frames
	// carry junk counts, which the block must ignore while a packet is open.
	task automatic queue_buffer(input int frames, input logic [15:0] head);
		in_item_t f;
		int       i;
		for (i = 0; i < frames; i++) begin
			f.left_raw    = random_sample();
			f.right_raw   = random_sample();
			f.is_silent   = ($urandom_range(99) < 8);
			f.frames_left = head - 16'(i);
			if (i > 0 && $urandom_range(9) == 0)
				f.frames_left = 16'($urandom());
			frames_to_send.push_back(f);
		end
	endtask

	initial begin
		logic [1:0] fmt_cycle [4];
		int         p, n, size, roll;
		logic [15:0] head;
		fmt_cycle = '{FMT_FLOAT32, FMT_PCM16, FMT_PCM24, FMT_PCM32};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values: pcm16, stereo, 48 kHz. Zero frames left acts as one,
		// a silent frame, and a short buffer with a junk count mid-packet.
		queue_frame(32'h1234_8001, 32'hFFFF_7FFF, 1'b0, 16'd0);
		queue_frame(32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 16'd1);
		queue_frame(32'h0000_FFFF, 32'hFFFF_0000, 1'b0, 16'd3);
		queue_frame(32'h5A5A_A5A5, 32'hA5A5_5A5A, 1'b0, 16'hFFFF);
		queue_frame(32'h0000_8000, 32'h0000_7FFF, 1'b0, 16'd1);
		wait_drained();

		// Float32 corners: NaN, infinities, exactly +-1, beyond range, rounding
		// near full scale, subnormals, signed zeros, and a silent frame.
		configure(FMT_FLOAT32, 2'd2, 32'hFFFF_FFFF);
		queue_frame(32'h7FC0_0000, 32'hFFFF_FFFF, 1'b0, 16'd9);
		queue_frame(32'h7F80_0000, 32'hFF80_0000, 1'b0, 16'd8);
		queue_frame(32'h3F80_0000, 32'hBF80_0000, 1'b0, 16'd7);
		queue_frame(32'h4049_0FDB, 32'hC2C8_0000, 1'b0, 16'd6);
		queue_frame(32'h3F00_0000, 32'hBF7F_FFFF, 1'b0, 16'd5);
		queue_frame(32'h0000_0001, 32'h807F_FFFF, 1'b0, 16'd4);
		queue_frame(32'h0000_0000, 32'h8000_0000, 1'b0, 16'd3);
		queue_frame(32'h3800_0000, 32'h3EFF_FFFF, 1'b0, 16'd2);
		queue_frame(32'h3F80_0000, 32'hBF80_0000, 1'b1, 16'd1);
		wait_drained();

		// Mono pcm24 at a rate of 1 Hz
		configure(FMT_PCM24, 2'd1, 32'd1);
		queue_frame(32'hA5C3_3C5A, 32'hFFFF_FFFF, 1'b0, 16'd2);
		queue_frame(32'h7F80_0001, 32'h0000_0000, 1'b0, 16'd1);
		wait_drained();

		// Channel count zero falls back to mono
		configure(FMT_PCM32, 2'd0, 32'd44100);
		queue_frame(32'h8000_1234, 32'h1234_8000, 1'b0, 16'd2);
		queue_frame(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 16'd1);
		wait_drained();

		// Channel count three falls back to stereo
		configure(FMT_PCM16, 2'd3, 32'd96000);
		queue_frame(32'hDEAD_BEEF, 32'hCAFE_F00D, 1'b0, 16'd2);
		queue_frame(32'h0001_FFFE, 32'hFFFE_0001, 1'b0, 16'd1);

		// Random phases: drain between them so the register writes land on an
		// idle block. Buffers are mostly short so packets open and close often;
		// some overrun their count so a packet spills into the next buffer.
		for (p = 0; p < 8; p++) begin
			wait_drained();
			configure(fmt_cycle[p % 4], 2'($urandom_range(3)),
			          (p == 0) ? 32'd1 : (p == 1) ? 32'hFFFF_FFFF : $urandom());
			no_idle = (p == 5);
			n = 0;
			while (n < ((p == 5) ? 14 : 5)) begin
				size = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
				roll = $urandom_range(19);
				if (roll == 0) begin
					size = 1;
					head = 16'd0;
				end else if (roll < 3) begin
					head = 16'(size + $urandom_range(1, 5));
				end else begin
					head = 16'(size);
				end
				queue_buffer(size, head);
				n += size;
			end
		end

		// One long buffer: the frame count caps at the packet limit
		wait_drained();
		no_idle = 1'b0;
		configure(FMT_FLOAT32, 2'd2, $urandom());
		queue_buffer(FRAMES_PER_PACKET, 16'($urandom_range(FRAMES_PER_PACKET, 65535)));

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d bytes in %0d packets from %0d frames over %0d register settings:",
		         bytes_checked, packets_seen, frames_accepted, settings_used + 1);
		$display("all four sample formats, channel counts 0 to 3, float corners, full-size packet.");
		if (mismatches == 0 && expected_bytes.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

### audio_sample_packetizer_unit.f
rtl/asp_pkg.sv
rtl/asp_lane.sv
rtl/asp_packer.sv
rtl/audio_sample_packetizer_unit.sv
rtl/asp_chk.sv
tb/testbench.sv
